FILE: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement unit.
// No dependencies; used by lrupr_cell and lru_page_replacement_unit.
package lrupr_pkg;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_UPD
  } state_t;

  // Per-cell update controls, driven by the sequencer.
  typedef struct packed {
    logic upd;
    logic shift;
    logic valid_next;
  } cell_ctl_t;

  localparam int CAP_W   = 10;
  localparam int CNT_W   = 32;
  localparam int OUT_W   = 72;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

endpackage

FILE: rtl/lrupr_cell.sv
// One recency slot of the LRU chain: page tag plus valid bit.
// Takes its neighbor's tag on a shift. Depends on lrupr_pkg.
module lrupr_cell #(
  parameter int PAGE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  left_tag,
  input  lrupr_pkg::cell_ctl_t  ctl,
  output logic [PAGE_BITS-1:0]  tag,
  output logic                  valid,
  output logic                  match
);

  logic [PAGE_BITS-1:0] tag_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (ctl.upd && ctl.shift) begin
      tag_q <= left_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.upd) begin
      valid_q <= ctl.valid_next;
    end
  end

  assign tag   = tag_q;
  assign valid = valid_q;
  assign match = valid_q && (tag_q == page);

endmodule

FILE: rtl/lrupr_scan.sv
// Suffix-OR unit: bit i of the result is the OR of input bits i and above.
// One doubling step per cycle, log2(N) steps after a load. No dependencies.
module lrupr_scan #(
  parameter int N = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [N-1:0] din,
  output logic [N-1:0] dout,
  output logic         busy
);

  localparam int STEPS = $clog2(N);
  localparam int K_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [N-1:0] vec_q;
  logic [K_W-1:0] k_q;
  logic busy_q;

  always_ff @(posedge clk) begin
    if (load) begin
      vec_q <= din;
    end else if (busy_q) begin
      vec_q <= vec_q | (vec_q >> (32'd1 << k_q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_q    <= '0;
      busy_q <= 1'b0;
    end else if (load) begin
      k_q    <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      k_q <= k_q + K_W'(1);
      if (k_q == K_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign dout = vec_q;
  assign busy = busy_q;

endmodule

FILE: rtl/lru_page_replacement_unit.sv
// Top level of the fully associative LRU page replacement unit.
// Depends on lrupr_pkg, lrupr_cell and lrupr_scan.
//
//  channel  dir  beat contents (tdata, low bit first)
//  s_*      in   page_number[PAGE_BITS], zero pad to bytes
//  m_*      out  hit[1], hit_count[32], fault_count[32], 7 bits zero
//  cfg_*    in   capacity[10], written when cfg_we is high
//
// A beat passes through accept, tag compare in every cell, clog2(FRAMES) suffix-OR
// steps in the scan unit, a state that sees the scan finish, then the chain update.
// A finished result waits in the output register; the next beat is taken meanwhile.
// A full output register that is not drained holds the chain update.
// Synchronous reset empties the chain and clears both counts; capacity reads 512.
module lru_page_replacement_unit #(
  parameter int FRAMES    = 512,
  parameter int PAGE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0] s_tdata,   // page_number
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lrupr_pkg::OUT_W-1:0]   m_tdata,    // hit, hit_count, fault_count
  input  logic                          cfg_we,
  input  logic [lrupr_pkg::CAP_W-1:0]   cfg_wdata   // capacity
);

  localparam int RES_W = $clog2(FRAMES + 1);

  lrupr_pkg::state_t state, state_next;

  logic [lrupr_pkg::CAP_W-1:0] capacity;
  logic [PAGE_BITS-1:0]        page_q;
  logic [RES_W-1:0]            resident;
  logic [lrupr_pkg::CNT_W-1:0] hits_q;
  logic [lrupr_pkg::CNT_W-1:0] faults_q;
  logic                        out_hit;
  logic [lrupr_pkg::CNT_W-1:0] out_hits;
  logic [lrupr_pkg::CNT_W-1:0] out_faults;

  logic [PAGE_BITS-1:0] tag_w [FRAMES];
  logic [FRAMES-1:0]    valid_w;
  logic [FRAMES-1:0]    match_w;
  logic [FRAMES-1:0]    suffix;
  logic                 scan_load;
  logic                 scan_busy;
  logic                 upd_fire;
  logic                 hit;
  logic [31:0]          eff32;
  logic [RES_W-1:0]     eff_cap;
  logic [RES_W-1:0]     newcount;

  // capacity zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    if (capacity == '0) begin
      eff32 = 32'd1;
    end else if ({22'd0, capacity} > 32'(FRAMES)) begin
      eff32 = 32'(FRAMES);
    end else begin
      eff32 = {22'd0, capacity};
    end
  end

  assign eff_cap  = eff32[RES_W-1:0];
  assign newcount = (resident < eff_cap) ? resident + RES_W'(1) : eff_cap;
  assign hit      = suffix[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrupr_pkg::CAP_W'(512);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      page_q <= s_tdata[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    scan_load  = 1'b0;
    upd_fire   = 1'b0;
    case (state)
      lrupr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = lrupr_pkg::ST_CMP;
        end
      end
      lrupr_pkg::ST_CMP: begin
        scan_load  = 1'b1;
        state_next = lrupr_pkg::ST_SCAN;
      end
      lrupr_pkg::ST_SCAN: begin
        if (!scan_busy) begin
          state_next = lrupr_pkg::ST_UPD;
        end
      end
      lrupr_pkg::ST_UPD: begin
        if (!m_tvalid || m_tready) begin
          upd_fire   = 1'b1;
          state_next = lrupr_pkg::ST_IDLE;
        end
      end
      default: state_next = lrupr_pkg::ST_IDLE;
    endcase
  end

  // cell 0 is most recent and loads the incoming page
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_pkg::cell_ctl_t ctl;
    logic [PAGE_BITS-1:0] left_tag;

    assign left_tag       = (i == 0) ? page_q : tag_w[(i == 0) ? 0 : i - 1];
    assign ctl.upd        = upd_fire;
    assign ctl.shift      = hit ? suffix[i] : (newcount > RES_W'(i));
    assign ctl.valid_next = hit ? valid_w[i] : (newcount > RES_W'(i));

    lrupr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .page     (page_q),
      .left_tag (left_tag),
      .ctl      (ctl),
      .tag      (tag_w[i]),
      .valid    (valid_w[i]),
      .match    (match_w[i])
    );
  end

  lrupr_scan #(
    .N(FRAMES)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .load (scan_load),
    .din  (match_w),
    .dout (suffix),
    .busy (scan_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      resident <= '0;
      hits_q   <= '0;
      faults_q <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (upd_fire) begin
        m_tvalid <= 1'b1;
        if (hit) begin
          if (hits_q != lrupr_pkg::CNT_SAT) begin
            hits_q <= hits_q + lrupr_pkg::CNT_W'(1);
          end
        end else begin
          resident <= newcount;
          if (faults_q != lrupr_pkg::CNT_SAT) begin
            faults_q <= faults_q + lrupr_pkg::CNT_W'(1);
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit    <= hit;
      out_hits   <= (hit && hits_q != lrupr_pkg::CNT_SAT) ?
                    hits_q + lrupr_pkg::CNT_W'(1) : hits_q;
      out_faults <= (!hit && faults_q != lrupr_pkg::CNT_SAT) ?
                    faults_q + lrupr_pkg::CNT_W'(1) : faults_q;
    end
  end

  assign m_tdata = {7'd0, out_faults, out_hits, out_hit};

  // resident pages always sit in a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("valid cells do not form a prefix");

  a_resident_count: assert property (@(posedge clk) disable iff (rst)
    32'($countones(valid_w)) == 32'(resident))
    else $error("resident count disagrees with valid cells");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lrupr_pkg::ST_IDLE) |-> !scan_busy)
    else $error("scan unit busy while idle");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && hit && hits_q != lrupr_pkg::CNT_SAT)
      |=> hits_q == $past(hits_q) + lrupr_pkg::CNT_W'(1))
    else $error("hit count did not advance on a hit");

  a_hit_no_grow: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && hit) |=> $stable(resident))
    else $error("resident count changed on a hit");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement_unit: directed table, then random traces.
// Depends on lrupr_pkg and the RTL of the unit; holds its own LRU predictor.
module testbench;

  localparam int FRAMES     = 512;
  localparam int PAGE_BITS  = 20;
  localparam int IN_W       = ((PAGE_BITS + 7) / 8) * 8;
  localparam int SETTLE     = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int NOISE_PCT  = 5;
  localparam int HIST_MAX   = 1024;
  localparam int NDIR       = 24;
  localparam int NPH        = 7;

  // random phases: capacity, beats, reuse window, share of fresh pages (percent)
  localparam int PH_CAP   [NPH] = '{4, 1, 0, 16, 5, 1023, 512};
  localparam int PH_BEATS [NPH] = '{60, 30, 25, 60, 45, 560, 60};
  localparam int PH_POOL  [NPH] = '{6, 2, 2, 20, 8, 80, 600};
  localparam int PH_FRESH [NPH] = '{20, 30, 30, 15, 15, 90, 0};

  typedef enum bit {ROW_ACCESS, ROW_CAP} row_kind_t;

  typedef struct packed {
    logic                        hit;
    logic [lrupr_pkg::CNT_W-1:0] hits;
    logic [lrupr_pkg::CNT_W-1:0] faults;
  } page_result_t;

  // data holds the raw s_tdata beat, or the capacity for ROW_CAP rows
  typedef struct packed {
    row_kind_t                   kind;
    logic [IN_W-1:0]             data;
    bit                          typed;
    bit                          e_hit;
    logic [lrupr_pkg::CNT_W-1:0] e_hits;
    logic [lrupr_pkg::CNT_W-1:0] e_faults;
  } dir_row_t;

  dir_row_t dir_rows [NDIR] = '{
    '{ROW_ACCESS, 24'h000000, 1'b1, 1'b0, 32'd0, 32'd1},
    '{ROW_ACCESS, 24'h0FFFFF, 1'b1, 1'b0, 32'd0, 32'd2},
    '{ROW_ACCESS, 24'h000000, 1'b1, 1'b1, 32'd1, 32'd2},
    '{ROW_ACCESS, 24'h0FFFFF, 1'b1, 1'b1, 32'd2, 32'd2},
    '{ROW_ACCESS, 24'hF00000, 1'b1, 1'b1, 32'd3, 32'd2},  // pad bits set, still page 0
    '{ROW_ACCESS, 24'h012345, 1'b1, 1'b0, 32'd3, 32'd3},
    '{ROW_ACCESS, 24'h0A5A5A, 1'b1, 1'b0, 32'd3, 32'd4},
    '{ROW_ACCESS, 24'h05A5A5, 1'b1, 1'b0, 32'd3, 32'd5},
    '{ROW_ACCESS, 24'h012345, 1'b1, 1'b1, 32'd4, 32'd5},
    '{ROW_ACCESS, 24'h0FFFFF, 1'b1, 1'b1, 32'd5, 32'd5},  // least recent page
    '{ROW_CAP,    24'd2,      1'b0, 1'b0, 32'd0, 32'd0},  // below resident count
    '{ROW_ACCESS, 24'h000000, 1'b1, 1'b1, 32'd6, 32'd5},  // found beyond capacity
    '{ROW_ACCESS, 24'h033333, 1'b1, 1'b0, 32'd6, 32'd6},  // chain cut to two
    '{ROW_ACCESS, 24'h0FFFFF, 1'b1, 1'b0, 32'd6, 32'd7},
    '{ROW_ACCESS, 24'h033333, 1'b1, 1'b1, 32'd7, 32'd7},
    '{ROW_CAP,    24'd0,      1'b0, 1'b0, 32'd0, 32'd0},  // zero acts as one
    '{ROW_ACCESS, 24'h044444, 1'b1, 1'b0, 32'd7, 32'd8},
    '{ROW_ACCESS, 24'h044444, 1'b1, 1'b1, 32'd8, 32'd8},
    '{ROW_ACCESS, 24'h033333, 1'b1, 1'b0, 32'd8, 32'd9},
    '{ROW_CAP,    24'd1023,   1'b0, 1'b0, 32'd0, 32'd0},  // clamps to FRAMES
    '{ROW_ACCESS, 24'h000001, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_ACCESS, 24'h080000, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_ACCESS, 24'h07FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_ACCESS, 24'h033333, 1'b0, 1'b0, 32'd0, 32'd0}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [IN_W-1:0]               s_tdata = '0;      // page_number[19:0], pad
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lrupr_pkg::OUT_W-1:0]   m_tdata;           // hit, hit_count, fault_count, pad
  logic                          cfg_we = 1'b0;
  logic [lrupr_pkg::CAP_W-1:0]   cfg_wdata = '0;    // capacity

  // predictor state
  logic [PAGE_BITS-1:0]          lru_tags [FRAMES];
  int                            resident = 0;
  logic [lrupr_pkg::CAP_W-1:0]   cap_reg = lrupr_pkg::CAP_W'(512);
  logic [lrupr_pkg::CNT_W-1:0]   hits_total = '0;
  logic [lrupr_pkg::CNT_W-1:0]   faults_total = '0;

  page_result_t         pending_results [$];
  logic [PAGE_BITS-1:0] page_hist [$];
  logic [PAGE_BITS-1:0] fresh_page = '0;
  bit                   src_idle = 1'b1;
  bit                   sink_idle = 1'b1;
  int                   sink_wait = 0;
  int                   err_cnt = 0;
  int                   sent_cnt = 0;
  int                   result_cnt = 0;
  int                   hit_beats = 0;
  int                   idle_cycles = 0;

  lru_page_replacement_unit #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic page_result_t lru_access(input logic [PAGE_BITS-1:0] page);
    page_result_t r;
    int slot;
    int eff;
    int fill;
    int i;
    slot = -1;
    for (i = 0; i < resident; i++) begin
      if (lru_tags[i] == page) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      for (i = slot; i > 0; i--) lru_tags[i] = lru_tags[i-1];
      lru_tags[0] = page;
      if (hits_total != lrupr_pkg::CNT_SAT) hits_total++;
      r.hit = 1'b1;
    end else begin
      eff = (cap_reg == 0) ? 1 : (cap_reg > FRAMES) ? FRAMES : int'(cap_reg);
      // a lowered capacity trims the chain on the next fault
      fill = (resident < eff) ? resident + 1 : eff;
      for (i = fill - 1; i > 0; i--) lru_tags[i] = lru_tags[i-1];
      lru_tags[0] = page;
      resident = fill;
      if (faults_total != lrupr_pkg::CNT_SAT) faults_total++;
      r.hit = 1'b0;
    end
    r.hits   = hits_total;
    r.faults = faults_total;
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_result(input logic [lrupr_pkg::OUT_W-1:0] beat);
    page_result_t want;
    page_result_t got;
    got.hit    = beat[0];
    got.hits   = beat[lrupr_pkg::CNT_W:1];
    got.faults = beat[2*lrupr_pkg::CNT_W:lrupr_pkg::CNT_W+1];
    result_cnt++;
    if (got.hit === 1'b1) hit_beats++;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result beat %0d with nothing outstanding", result_cnt));
      return;
    end
    want = pending_results.pop_front();
    if (got.hit !== want.hit)
      report_error($sformatf("beat %0d: hit %0b, want %0b", result_cnt, got.hit, want.hit));
    if (got.hits !== want.hits)
      report_error($sformatf("beat %0d: hit_count %0d, want %0d",
                             result_cnt, got.hits, want.hits));
    if (got.faults !== want.faults)
      report_error($sformatf("beat %0d: fault_count %0d, want %0d",
                             result_cnt, got.faults, want.faults));
  endtask

  // valid stays high across back-to-back beats; this task only drops it for a gap
  task automatic send_page(input logic [IN_W-1:0] raw, output page_result_t predicted);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = lru_access(raw[PAGE_BITS-1:0]);
    sent_cnt++;
  endtask

  task automatic set_capacity(input logic [lrupr_pkg::CAP_W-1:0] cap);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = cap;
  endtask

  // mostly fresh pages or re-touches of recent ones; a few raw random beats
  task automatic pick_page(input int pool, input int fresh_pct, output logic [IN_W-1:0] raw);
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (r < NOISE_PCT) begin
      raw = IN_W'($urandom());
    end else if (r < NOISE_PCT + fresh_pct || page_hist.size() == 0) begin
      raw = IN_W'(fresh_page);
      fresh_page++;
    end else begin
      span = (pool < page_hist.size()) ? pool : page_hist.size();
      raw = IN_W'(page_hist[page_hist.size() - 1 - $urandom_range(0, span - 1)]);
    end
    page_hist.push_back(raw[PAGE_BITS-1:0]);
    if (page_hist.size() > HIST_MAX) void'(page_hist.pop_front());
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        if (result_cnt % 32 == 0) sink_idle = $urandom_range(0, 1);
        sink_wait = sink_idle ? $urandom_range(0, 5) : 0;
        if (sink_wait != 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (sink_wait <= 1) begin
          sink_wait = 0;
          m_tready <= 1'b1;
        end else begin
          sink_wait--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    page_result_t pred;
    logic [IN_W-1:0] raw;
    int p;
    int k;
    fresh_page = PAGE_BITS'($urandom());
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < NDIR; k++) begin
      if (dir_rows[k].kind == ROW_CAP) begin
        set_capacity(dir_rows[k].data[lrupr_pkg::CAP_W-1:0]);
      end else begin
        send_page(dir_rows[k].data, pred);
        if (dir_rows[k].typed)
          pending_results.push_back('{dir_rows[k].e_hit, dir_rows[k].e_hits,
                                      dir_rows[k].e_faults});
        else
          pending_results.push_back(pred);
      end
    end

    for (p = 0; p < NPH; p++) begin
      set_capacity(lrupr_pkg::CAP_W'(PH_CAP[p]));
      for (k = 0; k < PH_BEATS[p]; k++) begin
        if (k % 32 == 0) src_idle = $urandom_range(0, 1);
        pick_page(PH_POOL[p], PH_FRESH[p], raw);
        send_page(raw, pred);
        pending_results.push_back(pred);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d page accesses, %0d result beats checked (%0d hits, %0d faults)",
             sent_cnt, result_cnt, hit_beats, result_cnt - hit_beats);
    $display("capacities 0, 1, 2, 4, 5, 16, 512 and 1023, incl. shrink and full-chain eviction");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
